@@ hw/rtl/mcl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcl_pkg
// shared types, character codes and classification helpers for the lexer
// ----------------------------------------------------------------------------
package mcl_pkg;

  localparam int FIFO_PTR_BITS = 2;
  localparam int FIFO_DEPTH    = 1 << FIFO_PTR_BITS;

  typedef enum logic [2:0] {
    KIND_INT    = 3'd0,
    KIND_RETURN = 3'd1,
    KIND_IDENT  = 3'd2,
    KIND_NUMBER = 3'd3,
    KIND_SYMBOL = 3'd4,
    KIND_EOF    = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_e;

  typedef enum logic [7:0] {
    MODE_IDLE   = 8'b0000_0001,
    MODE_IDENT  = 8'b0000_0010,
    MODE_NUMBER = 8'b0000_0100,
    MODE_SLASH  = 8'b0000_1000,
    MODE_LINE   = 8'b0001_0000,
    MODE_BLOCK  = 8'b0010_0000,
    MODE_STAR   = 8'b0100_0000,
    MODE_HALT   = 8'b1000_0000
  } mode_e;

  typedef enum logic [1:0] {
    KW_NONE   = 2'd0,
    KW_INT    = 2'd1,
    KW_RETURN = 2'd2
  } kw_e;

  typedef struct packed {
    logic one;
    logic two;
  } push_t;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_U     = 8'h75;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == CH_STAR || c == CH_PLUS || c == CH_MINUS || c == CH_EQ ||
           c == CH_SEMI || c == CH_COMMA || c == CH_LPAR || c == CH_RPAR ||
           c == CH_LBRC || c == CH_RBRC;
  endfunction

endpackage

@@ hw/rtl/mcl_result_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcl_result_fifo
// small token queue taking up to two entries per cycle, one out per transfer
// ----------------------------------------------------------------------------
module mcl_result_fifo #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcl_pkg::push_t       push_i,
  input  logic [DATA_BITS-1:0] data_a_i,
  input  logic [DATA_BITS-1:0] data_b_i,
  output logic                 busy_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output logic [DATA_BITS-1:0] data_o
);

  logic [DATA_BITS-1:0]             mem_q [mcl_pkg::FIFO_DEPTH];
  logic [mcl_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mcl_pkg::FIFO_PTR_BITS:0]   count_q, count_d;
  logic [mcl_pkg::FIFO_PTR_BITS-1:0] wr_next;
  logic                              pop;

  assign pop     = pop_i & valid_o;
  assign wr_next = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.two) begin
      wr_ptr_d = wr_ptr_q + 2'd2;
    end else if (push_i.one) begin
      wr_ptr_d = wr_next;
    end
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q
             + {{mcl_pkg::FIFO_PTR_BITS{1'b0}}, push_i.one}
             + {{mcl_pkg::FIFO_PTR_BITS{1'b0}}, push_i.two}
             - {{mcl_pkg::FIFO_PTR_BITS{1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.one) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_i.two) begin
      mem_q[wr_next] <= data_b_i;
    end
  end

  // keep room for two entries before taking another byte
  assign busy_o  = count_q > (mcl_pkg::FIFO_PTR_BITS + 1)'(mcl_pkg::FIFO_DEPTH - 2);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

@@ hw/rtl/mini_c_lexer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mini_c_lexer_top
// streaming scanner for a small c subset, one source byte per transfer
// ----------------------------------------------------------------------------
// Input channel: one source byte (ch_i) per transfer, or an end_of_input_i
// marker that flushes the pending token and emits an end-of-file token.
// Output channel: one token per transfer with kind, symbol or offending byte,
// number value, start offset, length, line, and last on the final token that
// a byte causes. Whitespace and both comment styles produce nothing.
// Throughput: one byte per cycle while the queue has room. The scanner state
// updates in the accepting cycle and the tokens are written into a four-entry
// queue, from whose head they are offered. A byte that ends one token and forms
// another gives two tokens; the queue drains one per cycle unless the output
// stalls, so a stream of such bytes runs at the output rate. The input stalls
// while the queue has no room for two tokens.
// Output stall holds the head token and backs up into the input stall.
// Reset empties the queue and returns the scanner to idle at offset and
// line zero. After an error token or end of file the scanner takes bytes
// but emits nothing until reset.
// ----------------------------------------------------------------------------
module mini_c_lexer_top #(
  parameter int POSITION_BITS = 16,
  parameter int NUMBER_BITS   = 32,
  parameter int LENGTH_BITS   = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               ch_i,
  input  logic                     end_of_input_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               kind_o,
  output logic [7:0]               symbol_char_o,
  output logic [NUMBER_BITS-1:0]   number_value_o,
  output logic [POSITION_BITS-1:0] token_start_o,
  output logic [LENGTH_BITS-1:0]   token_length_o,
  output logic [POSITION_BITS-1:0] line_number_o,
  output logic                     last_o
);

  typedef struct packed {
    mcl_pkg::kind_e           kind;
    logic [7:0]               sym;
    logic [NUMBER_BITS-1:0]   val;
    logic [POSITION_BITS-1:0] start;
    logic [LENGTH_BITS-1:0]   len;
    logic [POSITION_BITS-1:0] line;
    logic                     last;
  } rec_t;

  localparam int RecBits = $bits(rec_t);

  mcl_pkg::mode_e           mode_q, mode_d;
  mcl_pkg::kw_e             kw_q, kw_d;
  logic [NUMBER_BITS-1:0]   acc_q, acc_d;
  logic [LENGTH_BITS-1:0]   plen_q, plen_d;
  logic [POSITION_BITS-1:0] pstart_q, pstart_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] line_q, line_d;

  logic                     accept;
  logic                     fifo_busy;
  mcl_pkg::push_t           push;
  rec_t                     rec_a, rec_b, rec_out;
  logic [RecBits-1:0]       fifo_out;

  rec_t                     flush_rec, fresh_rec, sec_rec;
  logic                     flush_v, fresh_emit, sec_v, first_v;
  logic                     do_flush, do_fresh;
  mcl_pkg::mode_e           fresh_mode;
  mcl_pkg::kw_e             fresh_kw;
  logic                     fresh_pending, fresh_nl;
  logic                     kw_ok;
  logic [NUMBER_BITS+3:0]   acc_x10;
  logic [7:0]               c;

  assign c      = ch_i;
  assign accept = in_valid_i & ~in_stall_o;

  // pending token at the moment it is ended
  always_comb begin
    flush_rec      = '0;
    flush_rec.line = line_q;
    flush_rec.start = pstart_q;
    flush_rec.len  = plen_q;
    flush_v        = 1'b0;
    flush_rec.kind = mcl_pkg::KIND_IDENT;
    case (mode_q)
      mcl_pkg::MODE_IDENT: begin
        flush_v = 1'b1;
        if (kw_q == mcl_pkg::KW_INT && plen_q == LENGTH_BITS'(3)) begin
          flush_rec.kind = mcl_pkg::KIND_INT;
        end else if (kw_q == mcl_pkg::KW_RETURN && plen_q == LENGTH_BITS'(6)) begin
          flush_rec.kind = mcl_pkg::KIND_RETURN;
        end
      end
      mcl_pkg::MODE_NUMBER: begin
        flush_v        = 1'b1;
        flush_rec.kind = mcl_pkg::KIND_NUMBER;
        flush_rec.val  = acc_q;
      end
      mcl_pkg::MODE_SLASH: begin
        flush_v        = 1'b1;
        flush_rec.kind = mcl_pkg::KIND_SYMBOL;
        flush_rec.sym  = mcl_pkg::CH_SLASH;
        flush_rec.len  = LENGTH_BITS'(1);
      end
      default: begin
        flush_v = 1'b0;
      end
    endcase
  end

  // byte scanned from idle
  always_comb begin
    fresh_rec       = '0;
    fresh_rec.kind  = mcl_pkg::KIND_SYMBOL;
    fresh_rec.start = pos_q;
    fresh_rec.len   = LENGTH_BITS'(1);
    fresh_rec.line  = line_q;
    fresh_emit      = 1'b0;
    fresh_mode      = mcl_pkg::MODE_IDLE;
    fresh_pending   = 1'b0;
    fresh_nl        = 1'b0;
    fresh_kw        = mcl_pkg::KW_NONE;
    if (c == mcl_pkg::CH_I) begin
      fresh_kw = mcl_pkg::KW_INT;
    end else if (c == mcl_pkg::CH_R) begin
      fresh_kw = mcl_pkg::KW_RETURN;
    end
    if (mcl_pkg::is_space(c)) begin
      fresh_nl = c == mcl_pkg::CH_NL;
    end else if (mcl_pkg::is_letter(c)) begin
      fresh_mode    = mcl_pkg::MODE_IDENT;
      fresh_pending = 1'b1;
    end else if (c == mcl_pkg::CH_ZERO) begin
      fresh_emit     = 1'b1;
      fresh_rec.kind = mcl_pkg::KIND_NUMBER;
    end else if (mcl_pkg::is_digit(c)) begin
      fresh_mode    = mcl_pkg::MODE_NUMBER;
      fresh_pending = 1'b1;
    end else if (c == mcl_pkg::CH_SLASH) begin
      fresh_mode    = mcl_pkg::MODE_SLASH;
      fresh_pending = 1'b1;
    end else if (mcl_pkg::is_symbol(c)) begin
      fresh_emit    = 1'b1;
      fresh_rec.sym = c;
    end else begin
      fresh_emit     = 1'b1;
      fresh_rec.kind = mcl_pkg::KIND_ERROR;
      fresh_rec.sym  = c;
      fresh_mode     = mcl_pkg::MODE_HALT;
    end
  end

  // keyword still possible after this byte
  always_comb begin
    kw_ok = 1'b0;
    if (kw_q == mcl_pkg::KW_INT) begin
      kw_ok = (plen_q == LENGTH_BITS'(0) && c == mcl_pkg::CH_I) ||
              (plen_q == LENGTH_BITS'(1) && c == mcl_pkg::CH_N) ||
              (plen_q == LENGTH_BITS'(2) && c == mcl_pkg::CH_T);
    end else if (kw_q == mcl_pkg::KW_RETURN) begin
      kw_ok = (plen_q == LENGTH_BITS'(0) && c == mcl_pkg::CH_R) ||
              (plen_q == LENGTH_BITS'(1) && c == mcl_pkg::CH_E) ||
              (plen_q == LENGTH_BITS'(2) && c == mcl_pkg::CH_T) ||
              (plen_q == LENGTH_BITS'(3) && c == mcl_pkg::CH_U) ||
              (plen_q == LENGTH_BITS'(4) && c == mcl_pkg::CH_R) ||
              (plen_q == LENGTH_BITS'(5) && c == mcl_pkg::CH_N);
    end
  end

  assign acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                 + (NUMBER_BITS + 4)'(c[3:0]);

  always_comb begin
    mode_d   = mode_q;
    kw_d     = kw_q;
    acc_d    = acc_q;
    plen_d   = plen_q;
    pstart_d = pstart_q;
    pos_d    = pos_q;
    line_d   = line_q;
    do_flush = 1'b0;
    do_fresh = 1'b0;
    if (accept && mode_q != mcl_pkg::MODE_HALT) begin
      if (end_of_input_i) begin
        do_flush = 1'b1;
        mode_d   = mcl_pkg::MODE_HALT;
      end else begin
        case (mode_q)
          mcl_pkg::MODE_IDENT: begin
            if (mcl_pkg::is_letter(c) || mcl_pkg::is_digit(c)) begin
              if (!kw_ok) begin
                kw_d = mcl_pkg::KW_NONE;
              end
              plen_d = (plen_q == '1) ? plen_q : plen_q + 1'b1;
            end else begin
              do_flush = 1'b1;
              do_fresh = 1'b1;
            end
          end
          mcl_pkg::MODE_NUMBER: begin
            if (mcl_pkg::is_digit(c)) begin
              acc_d  = (acc_x10[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) ? '1
                     : acc_x10[NUMBER_BITS-1:0];
              plen_d = (plen_q == '1) ? plen_q : plen_q + 1'b1;
            end else begin
              do_flush = 1'b1;
              do_fresh = 1'b1;
            end
          end
          mcl_pkg::MODE_SLASH: begin
            if (c == mcl_pkg::CH_SLASH) begin
              mode_d = mcl_pkg::MODE_LINE;
            end else if (c == mcl_pkg::CH_STAR) begin
              mode_d = mcl_pkg::MODE_BLOCK;
            end else begin
              do_flush = 1'b1;
              do_fresh = 1'b1;
            end
          end
          mcl_pkg::MODE_LINE: begin
            if (c == mcl_pkg::CH_NL) begin
              line_d = (line_q == '1) ? line_q : line_q + 1'b1;
              mode_d = mcl_pkg::MODE_IDLE;
            end
          end
          mcl_pkg::MODE_BLOCK, mcl_pkg::MODE_STAR: begin
            if (mode_q == mcl_pkg::MODE_STAR && c == mcl_pkg::CH_SLASH) begin
              mode_d = mcl_pkg::MODE_IDLE;
            end else if (c == mcl_pkg::CH_STAR) begin
              mode_d = mcl_pkg::MODE_STAR;
            end else begin
              if (c == mcl_pkg::CH_NL) begin
                line_d = (line_q == '1) ? line_q : line_q + 1'b1;
              end
              mode_d = mcl_pkg::MODE_BLOCK;
            end
          end
          default: begin
            do_fresh = 1'b1;
          end
        endcase
        if (do_fresh) begin
          mode_d = fresh_mode;
          if (fresh_pending) begin
            pstart_d = pos_q;
            plen_d   = LENGTH_BITS'(1);
            kw_d     = fresh_kw;
            acc_d    = NUMBER_BITS'(c[3:0]);
          end
          if (fresh_nl) begin
            line_d = (line_q == '1) ? line_q : line_q + 1'b1;
          end
        end
        pos_d = (pos_q == '1) ? pos_q : pos_q + 1'b1;
      end
    end
  end

  // end-of-file token takes the second slot behind a flushed token, else the first
  always_comb begin
    sec_rec = fresh_rec;
    sec_v   = do_fresh & fresh_emit;
    if (accept && end_of_input_i && mode_q != mcl_pkg::MODE_HALT) begin
      sec_rec       = '0;
      sec_rec.kind  = mcl_pkg::KIND_EOF;
      sec_rec.start = pos_q;
      sec_rec.line  = line_q;
      sec_v         = 1'b1;
    end
    first_v  = do_flush & flush_v;
    rec_a    = first_v ? flush_rec : sec_rec;
    rec_b    = sec_rec;
    push.one = first_v | sec_v;
    push.two = first_v & sec_v;
    rec_a.last = ~push.two;
    rec_b.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mcl_pkg::MODE_IDLE;
      kw_q     <= mcl_pkg::KW_NONE;
      acc_q    <= '0;
      plen_q   <= '0;
      pstart_q <= '0;
      pos_q    <= '0;
      line_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      kw_q     <= kw_d;
      acc_q    <= acc_d;
      plen_q   <= plen_d;
      pstart_q <= pstart_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
    end
  end

  mcl_result_fifo #(
    .DATA_BITS(RecBits)
  ) u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_a_i(rec_a),
    .data_b_i(rec_b),
    .busy_o  (fifo_busy),
    .valid_o (out_valid_o),
    .pop_i   (~out_stall_i),
    .data_o  (fifo_out)
  );

  assign in_stall_o     = fifo_busy;
  assign rec_out        = rec_t'(fifo_out);
  assign kind_o         = rec_out.kind;
  assign symbol_char_o  = rec_out.sym;
  assign number_value_o = rec_out.val;
  assign token_start_o  = rec_out.start;
  assign token_length_o = rec_out.len;
  assign line_number_o  = rec_out.line;
  assign last_o         = rec_out.last;

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == mcl_pkg::MODE_HALT |=> mode_q == mcl_pkg::MODE_HALT)
    else $error("scanner left halt without reset");

  a_eof_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_input_i |=> mode_q == mcl_pkg::MODE_HALT)
    else $error("end of input did not halt the scanner");

  a_line_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> line_q >= $past(line_q))
    else $error("line counter went backwards");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> pos_q >= $past(pos_q))
    else $error("byte offset went backwards");
`endif

endmodule
